// ===== hdl/indexed_sequence_store_unit_macros.svh =====
// Assertion macros for the indexed sequence store unit.
// Used by modules that carry concurrent checks; expects aclk and aresetn in scope.
`ifndef INDEXED_SEQUENCE_STORE_UNIT_MACROS_SVH
`define INDEXED_SEQUENCE_STORE_UNIT_MACROS_SVH

// check held outside reset
`define ISU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// check held at every edge, reset included
`define ISU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/isu_pkg.sv =====
// Package for the indexed sequence store unit: defaults, action and status codes,
// and the per-cell control struct. No dependencies.
package isu_pkg;

    localparam int unsigned CAPACITY_DEF   = 16;
    localparam int unsigned DATA_WIDTH_DEF = 32;
    localparam int unsigned ACTION_W       = 3;
    localparam int unsigned STATUS_W       = 2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_INSERT      = 3'd0,
        ACT_REMOVE_AT   = 3'd1,
        ACT_REMOVE_LAST = 3'd2,
        ACT_FIND        = 3'd3,
        ACT_QUERY       = 3'd4
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic load;
        logic take_left;
        logic take_right;
    } cell_ctrl_t;

endpackage

// ===== hdl/isu_cell.sv =====
// One storage cell of the chain: holds a single entry, shifts from either
// neighbour or loads the new word, and flags equality with the search word. Uses isu_pkg.
module isu_cell #(
    parameter int unsigned DATA_WIDTH = isu_pkg::DATA_WIDTH_DEF
) (
    input  logic                   aclk,
    input  isu_pkg::cell_ctrl_t    ctrl,
    input  logic [DATA_WIDTH-1:0]  left_data,
    input  logic [DATA_WIDTH-1:0]  right_data,
    input  logic [DATA_WIDTH-1:0]  value,
    output logic [DATA_WIDTH-1:0]  data,
    output logic                   match
);
    import isu_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            data_reg <= value;
        end else if (ctrl.take_left) begin
            data_reg <= left_data;
        end else if (ctrl.take_right) begin
            data_reg <= right_data;
        end
    end

    assign data  = data_reg;
    assign match = (data_reg == value);

endmodule

// ===== hdl/indexed_sequence_store_unit.sv =====
// Indexed sequence store: a chain of isu_cell entries with count and result logic.
// A transaction passes the cell update stage, then the priority encode and back-entry
// select stage into the output register; no new one is taken before that.
// Input is taken again while a result waits in the output register.
// Reset (aresetn low, synchronous) empties the store and drops pending results;
// entry storage is not cleared. Depends on isu_pkg, isu_cell and the macros header.
module indexed_sequence_store_unit #(
    parameter int unsigned CAPACITY   = isu_pkg::CAPACITY_DEF,
    parameter int unsigned DATA_WIDTH = isu_pkg::DATA_WIDTH_DEF,
    localparam int unsigned CNT_W     = $clog2(CAPACITY + 1),
    localparam int unsigned IN_BITS   = isu_pkg::ACTION_W + CNT_W + DATA_WIDTH,
    localparam int unsigned IN_W      = ((IN_BITS + 7) / 8) * 8,
    localparam int unsigned OUT_BITS  = isu_pkg::STATUS_W + 2 * CNT_W + 2 * DATA_WIDTH + 1,
    localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // action, position, value
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // status, found_index, front_value, back_value,
                                        // item_count, is_empty
);
    import isu_pkg::*;
    `include "indexed_sequence_store_unit_macros.svh"

    localparam int unsigned IDX_W = $clog2(CAPACITY);
    localparam int unsigned A_LO  = 0;
    localparam int unsigned P_LO  = ACTION_W;
    localparam int unsigned V_LO  = ACTION_W + CNT_W;
    localparam int unsigned O_FI  = STATUS_W;
    localparam int unsigned O_FR  = O_FI + CNT_W;
    localparam int unsigned O_BK  = O_FR + DATA_WIDTH;
    localparam int unsigned O_CT  = O_BK + DATA_WIDTH;
    localparam int unsigned O_EM  = O_CT + CNT_W;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    logic                  s_accept;
    action_t               s_action;
    logic [CNT_W-1:0]      s_position;
    logic [DATA_WIDTH-1:0] s_value;
    logic [CNT_W-1:0]      ins_pos;
    logic                  ins_ok;
    logic                  rem_ok;

    logic [CNT_W-1:0]      count_reg, count_next;
    logic                  busy_reg;
    status_t               pend_status_reg, pend_status_next;
    logic                  pend_find_reg;
    logic [CAPACITY-1:0]   pend_match_reg;

    cell_ctrl_t            cell_ctrl  [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_data  [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_left  [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_right [CAPACITY];
    logic [CAPACITY-1:0]   cell_match;

    logic                  out_load;
    logic                  m_tvalid_reg;
    status_t               m_status_reg;
    logic [CNT_W-1:0]      m_found_reg, found_next;
    logic [DATA_WIDTH-1:0] m_front_reg, front_next;
    logic [DATA_WIDTH-1:0] m_back_reg, back_next;
    logic [CNT_W-1:0]      m_count_reg;
    logic                  m_empty_reg;
    logic [IDX_W-1:0]      back_idx;

    assign s_tready   = !busy_reg;
    assign s_accept   = s_tvalid && s_tready;
    assign s_action   = action_t'(s_tdata[A_LO +: ACTION_W]);
    assign s_position = s_tdata[P_LO +: CNT_W];
    assign s_value    = s_tdata[V_LO +: DATA_WIDTH];
    assign ins_pos    = (s_position > count_reg) ? count_reg : s_position;
    assign ins_ok     = s_accept && (s_action == ACT_INSERT) && (count_reg != CAP_C);
    assign rem_ok     = s_accept && (s_action == ACT_REMOVE_AT) && (s_position < count_reg);

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(i);

        if (i == 0) begin : g_first
            assign cell_left[i] = '0;
        end else begin : g_mid
            assign cell_left[i] = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign cell_right[i] = '0;
        end else begin : g_inner
            assign cell_right[i] = cell_data[i+1];
        end

        assign cell_ctrl[i].load       = ins_ok && (IDX == ins_pos);
        assign cell_ctrl[i].take_left  = ins_ok && (IDX > ins_pos);
        assign cell_ctrl[i].take_right = rem_ok && (IDX >= s_position);

        isu_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl[i]),
            .left_data  (cell_left[i]),
            .right_data (cell_right[i]),
            .value      (s_value),
            .data       (cell_data[i]),
            .match      (cell_match[i])
        );
    end

    always_comb begin
        count_next       = count_reg;
        pend_status_next = ST_DONE;
        case (s_action)
            ACT_INSERT: begin
                if (count_reg == CAP_C) begin
                    pend_status_next = ST_FULL;
                end else begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_REMOVE_AT: begin
                if (s_position >= count_reg) begin
                    pend_status_next = ST_RANGE;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ACT_REMOVE_LAST: begin
                if (count_reg == '0) begin
                    pend_status_next = ST_RANGE;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            busy_reg  <= 1'b0;
        end else begin
            if (s_accept) begin
                count_reg <= count_next;
                busy_reg  <= 1'b1;
            end else if (out_load) begin
                busy_reg  <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            pend_status_reg <= pend_status_next;
            pend_find_reg   <= (s_action == ACT_FIND);
            for (int i = 0; i < CAPACITY; i++) begin
                pend_match_reg[i] <= cell_match[i] && (CNT_W'(i) < count_reg);
            end
        end
    end

    // result stage
    assign out_load = busy_reg && (!m_tvalid_reg || m_tready);
    assign back_idx = IDX_W'(count_reg - CNT_W'(1));

    always_comb begin
        found_next = count_reg;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (pend_match_reg[i]) begin
                found_next = CNT_W'(i);
            end
        end
        if (!pend_find_reg) begin
            found_next = '0;
        end
        front_next = (count_reg == '0) ? '0 : cell_data[0];
        back_next  = (count_reg == '0) ? '0 : cell_data[back_idx];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_status_reg <= pend_status_reg;
            m_found_reg  <= found_next;
            m_front_reg  <= front_next;
            m_back_reg   <= back_next;
            m_count_reg  <= count_reg;
            m_empty_reg  <= (count_reg == '0);
        end
    end

    assign m_tvalid = m_tvalid_reg;

    always_comb begin
        m_tdata                     = '0;
        m_tdata[0 +: STATUS_W]      = m_status_reg;
        m_tdata[O_FI +: CNT_W]      = m_found_reg;
        m_tdata[O_FR +: DATA_WIDTH] = m_front_reg;
        m_tdata[O_BK +: DATA_WIDTH] = m_back_reg;
        m_tdata[O_CT +: CNT_W]      = m_count_reg;
        m_tdata[O_EM]               = m_empty_reg;
    end

    `ISU_ASSERT(a_count_bound, count_reg <= CAP_C, "entry count above capacity")
    `ISU_ASSERT(a_accept_busy, s_accept |=> busy_reg, "transaction taken without going busy")
    `ISU_ASSERT(a_count_step, (count_reg != $past(count_reg)) |-> $past(s_accept), "count moved without a transaction")
    `ISU_ASSERT(a_empty_flag, m_tvalid_reg |-> (m_empty_reg == (m_count_reg == '0)), "empty flag disagrees with count")

endmodule

// ===== dv/indexed_sequence_store_unit_tb.sv =====
// Testbench for indexed_sequence_store_unit: directed and random actions on the stream input,
// results checked against a behavioural store held in a small scoreboard class.
// Depends on isu_pkg and the indexed_sequence_store_unit RTL.
module indexed_sequence_store_unit_tb;
    import isu_pkg::*;

    localparam int unsigned CAP      = CAPACITY_DEF;
    localparam int unsigned IN_W     = 40;
    localparam int unsigned OUT_W    = 80;
    localparam int unsigned LIMIT    = 200000;
    localparam int unsigned HOLD_OFF = 300;

    typedef struct packed {
        status_t     status;
        logic [4:0]  found;
        logic [31:0] front;
        logic [31:0] back;
        logic [4:0]  count;
        logic        empty;
    } store_view_t;

    class store_scoreboard;
        logic [31:0]  words[CAP];
        int unsigned  fill;
        store_view_t  expected_views[$];
        int unsigned  mismatches;

        function new();
            fill = 0;
            mismatches = 0;
        endfunction

        function int unsigned pending();
            return expected_views.size();
        endfunction

        function void note_action(logic [IN_W-1:0] d);
            action_t     act;
            logic [4:0]  pos;
            logic [31:0] val;
            store_view_t v;
            int unsigned p;
            int unsigned i;
            act = action_t'(d[2:0]);
            pos = d[7:3];
            val = d[39:8];
            v = '0;
            v.status = ST_DONE;
            case (act)
                ACT_INSERT: begin
                    if (fill >= CAP) begin
                        v.status = ST_FULL;
                    end else begin
                        p = (pos > fill) ? fill : pos;
                        for (i = fill; i > p; i--)
                            words[i] = words[i-1];
                        words[p] = val;
                        fill++;
                    end
                end
                ACT_REMOVE_AT: begin
                    if (pos >= fill) begin
                        v.status = ST_RANGE;
                    end else begin
                        for (i = pos; i + 1 < fill; i++)
                            words[i] = words[i+1];
                        fill--;
                    end
                end
                ACT_REMOVE_LAST: begin
                    if (fill == 0)
                        v.status = ST_RANGE;
                    else
                        fill--;
                end
                ACT_FIND: begin
                    v.found = fill[4:0];
                    for (i = 0; i < fill; i++) begin
                        if (words[i] == val) begin
                            v.found = i[4:0];
                            break;
                        end
                    end
                end
                default: ;
            endcase
            v.front = (fill > 0) ? words[0] : '0;
            v.back  = (fill > 0) ? words[fill-1] : '0;
            v.count = fill[4:0];
            v.empty = (fill == 0);
            expected_views.insert(expected_views.size(), v);
        endfunction

        function void check_result(logic [OUT_W-1:0] d);
            store_view_t got;
            store_view_t exp;
            string       bad;
            got.status = status_t'(d[1:0]);
            got.found  = d[6:2];
            got.front  = d[38:7];
            got.back   = d[70:39];
            got.count  = d[75:71];
            got.empty  = d[76];
            if (expected_views.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transaction: %p", got);
                return;
            end
            exp = expected_views[0];
            expected_views.delete(0);
            bad = "";
            if (got.status !== exp.status) bad = {bad, " status"};
            if (got.found  !== exp.found)  bad = {bad, " found_index"};
            if (got.front  !== exp.front)  bad = {bad, " front_value"};
            if (got.back   !== exp.back)   bad = {bad, " back_value"};
            if (got.count  !== exp.count)  bad = {bad, " item_count"};
            if (got.empty  !== exp.empty)  bad = {bad, " is_empty"};
            if (bad != "") begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch in%s: expected %p, got %p", bad, exp, got);
            end
        endfunction
    endclass

    logic             aclk;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic             m_tvalid;
    logic             m_tready;
    logic [OUT_W-1:0] m_tdata;

    store_scoreboard sb;
    int unsigned     send_idle;
    int unsigned     recv_idle;
    int unsigned     phase;
    int unsigned     cycle_count;
    logic [31:0]     value_pool[8];

    indexed_sequence_store_unit DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    function automatic logic [IN_W-1:0] pack_action(action_t a, logic [4:0] p, logic [31:0] v);
        return {v, p, a};
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic push_action(logic [IN_W-1:0] d);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do @(posedge aclk); while (!s_tready);
        sb.note_action(d);
        @(negedge aclk);
    endtask

    task automatic random_actions(int unsigned n);
        int unsigned k;
        int unsigned r;
        int unsigned run_left;
        bit          filling;
        action_t     a;
        logic [4:0]  p;
        logic [31:0] v;
        run_left = 0;
        filling  = 1'b1;
        for (k = 0; k < n; k++) begin
            if (run_left == 0) begin
                filling  = ~filling;
                run_left = $urandom_range(10, 50);
            end
            run_left--;
            r = $urandom_range(0, 99);
            if (filling)
                a = (r < 55) ? ACT_INSERT : (r < 70) ? ACT_FIND : (r < 80) ? ACT_REMOVE_AT :
                    (r < 90) ? ACT_REMOVE_LAST : (r < 95) ? ACT_QUERY :
                    action_t'(3'($urandom_range(5, 7)));
            else
                a = (r < 15) ? ACT_INSERT : (r < 30) ? ACT_FIND : (r < 60) ? ACT_REMOVE_AT :
                    (r < 90) ? ACT_REMOVE_LAST : (r < 95) ? ACT_QUERY :
                    action_t'(3'($urandom_range(5, 7)));
            p = ($urandom_range(0, 99) < 85) ? 5'($urandom_range(0, 17))
                                              : 5'($urandom_range(0, 31));
            v = ($urandom_range(0, 1) == 0) ? value_pool[$urandom_range(0, 7)] : $urandom;
            push_action(pack_action(a, p, v));
        end
    endtask

    // receiver: random back-pressure, one long hold-off early in the second phase
    initial begin
        int unsigned hold_left;
        bit          held;
        hold_left = 0;
        held      = 1'b0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else if (phase == 1 && !held) begin
                held      = 1'b1;
                hold_left = HOLD_OFF - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    initial begin
        int unsigned i;
        sb          = new();
        cycle_count = 0;
        phase       = 0;
        send_idle   = 32;
        recv_idle   = 49;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        value_pool  = '{32'h0, 32'h1, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                        32'h5555_5555, 32'haaaa_aaaa, 32'd42};
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // empty store corner cases
        push_action(pack_action(ACT_QUERY, 5'd0, 32'h0));
        push_action(pack_action(ACT_REMOVE_LAST, 5'd0, 32'h0));
        push_action(pack_action(ACT_REMOVE_AT, 5'd0, 32'h0));
        push_action(pack_action(ACT_FIND, 5'd0, 32'h0));
        push_action(pack_action(action_t'(3'd7), 5'd31, 32'hffff_ffff));
        // extremes, append by clamping, front insert
        push_action(pack_action(ACT_INSERT, 5'd0, 32'h7fff_ffff));
        push_action(pack_action(ACT_INSERT, 5'd31, 32'h8000_0000));
        push_action(pack_action(ACT_INSERT, 5'd1, 32'h0));
        push_action(pack_action(ACT_INSERT, 5'd0, 32'hffff_ffff));
        push_action(pack_action(ACT_FIND, 5'd0, 32'h0));
        push_action(pack_action(ACT_FIND, 5'd0, 32'd12345));
        for (i = 0; i < 12; i++)
            push_action(pack_action(ACT_INSERT, 5'((i * 3) % 20), 32'(i * 32'h1357_9bdf)));
        // full store, an out of range remove, removes at the front and the back, undefined actions
        push_action(pack_action(ACT_INSERT, 5'd4, 32'hdead_beef));
        push_action(pack_action(ACT_REMOVE_AT, 5'd16, 32'h0));
        push_action(pack_action(ACT_REMOVE_AT, 5'd0, 32'h0));
        push_action(pack_action(ACT_REMOVE_AT, 5'd14, 32'h0));
        push_action(pack_action(action_t'(3'd5), 5'd3, 32'h0));
        push_action(pack_action(action_t'(3'd6), 5'd21, 32'h1));

        random_actions(670);
        phase     = 1;
        send_idle = 49;
        recv_idle = 32;
        random_actions(670);
        phase     = 2;
        send_idle = 0;
        recv_idle = 0;
        random_actions(670);
        s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hdl
hdl/isu_pkg.sv
hdl/isu_cell.sv
hdl/indexed_sequence_store_unit.sv
dv/indexed_sequence_store_unit_tb.sv
